### hw/rtl/bmp_stream_to_framebuffer_writer_defines.svh
// Assertion macros shared by the RTL.
`ifndef BMP_STREAM_TO_FRAMEBUFFER_WRITER_DEFINES_SVH
`define BMP_STREAM_TO_FRAMEBUFFER_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define BMP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BMP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/bmp_fb_pkg.sv
`timescale 1ns / 1ps

package bmp_fb_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int HEADER_BYTES  = 54;
  localparam int FB_WORDS      = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int ADDR_W  = 19;
  localparam int PIXEL_W = 24;
  localparam int DX_W    = 10;
  localparam int DY_W    = 9;
  localparam int WID_W   = 10;
  localparam int HGT_W   = 9;
  localparam int HDR_W   = 6;
  localparam int SCOL_W  = DX_W + 1;
  localparam int SROW_W  = DY_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X       = 2'd0,
    CFG_DEST_Y       = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DX_W-1:0]  dest_x;
    logic [DY_W-1:0]  dest_y;
    logic [WID_W-1:0] image_width;
    logic [HGT_W-1:0] image_height;
  } cfg_t;

  // one on-screen pixel write, before address generation
  typedef struct packed {
    logic [SROW_W-1:0]  row;
    logic [SCOL_W-1:0]  col;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pix_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

endpackage

### hw/rtl/bmp_fb_if.sv
`timescale 1ns / 1ps

interface bmp_fb_byte_if import bmp_fb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, data_byte, start_of_file, input ready);
  modport sink (input valid, data_byte, start_of_file, output ready);
endinterface

interface bmp_fb_pix_if import bmp_fb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  fb_address;
  logic [PIXEL_W-1:0] pixel_value;
  logic               last_pixel;

  modport source (output valid, fb_address, pixel_value, last_pixel, input ready);
  modport sink (input valid, fb_address, pixel_value, last_pixel, output ready);
endinterface

### hw/rtl/bmp_fb_front.sv
`timescale 1ns / 1ps

module bmp_fb_front import bmp_fb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  bmp_fb_byte_if.sink       byte_in,
  input  logic              q_full_i,
  output logic              push_o,
  output pix_cmd_t          cmd_o
);

  logic [HDR_W-1:0] header_left_q, header_left_d;
  logic [1:0]       byte_phase_q, byte_phase_d;
  logic [15:0]      blue_green_q, blue_green_d;
  logic [WID_W-1:0] column_q, column_d;
  logic [HGT_W-1:0] row_q, row_d;
  logic [1:0]       pad_left_q, pad_left_d;
  logic             done_q, done_d;

  logic [HDR_W-1:0] hl;
  logic [1:0]       ph, pad;
  logic [15:0]      bg;
  logic [WID_W-1:0] col;
  logic [HGT_W-1:0] row;
  logic             dn;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [SCOL_W-1:0] scr_col;
  logic [SROW_W-1:0] scr_row;
  logic             accept;

  assign byte_in.ready = !q_full_i;
  assign accept = byte_in.valid && byte_in.ready;

  assign w_eff = (cfg_i.image_width == '0) ? WID_W'(1) : cfg_i.image_width;
  assign h_eff = (cfg_i.image_height == '0) ? HGT_W'(1) : cfg_i.image_height;

  always_comb begin
    header_left_d = header_left_q;
    byte_phase_d  = byte_phase_q;
    blue_green_d  = blue_green_q;
    column_d      = column_q;
    row_d         = row_q;
    pad_left_d    = pad_left_q;
    done_d        = done_q;
    push_o        = 1'b0;

    // start_of_file restarts the counters before the byte is looked at
    if (byte_in.start_of_file) begin
      hl  = HDR_W'(HEADER_BYTES);
      ph  = '0;
      bg  = '0;
      col = '0;
      row = '0;
      pad = '0;
      dn  = 1'b0;
    end else begin
      hl  = header_left_q;
      ph  = byte_phase_q;
      bg  = blue_green_q;
      col = column_q;
      row = row_q;
      pad = pad_left_q;
      dn  = done_q;
    end

    scr_col = SCOL_W'(cfg_i.dest_x) + SCOL_W'(col);
    scr_row = SROW_W'(cfg_i.dest_y) + SROW_W'(h_eff - HGT_W'(1) - row);

    cmd_o.row   = scr_row;
    cmd_o.col   = scr_col;
    cmd_o.pixel = {byte_in.data_byte, bg};
    cmd_o.last  = 1'b0;

    if (accept) begin
      header_left_d = hl;
      byte_phase_d  = ph;
      blue_green_d  = bg;
      column_d      = col;
      row_d         = row;
      pad_left_d    = pad;
      done_d        = dn;
      if (dn) begin
        // trailing bytes after the image are dropped
      end else if (hl != '0) begin
        header_left_d = hl - HDR_W'(1);
      end else if (pad != '0) begin
        pad_left_d = pad - 2'd1;
      end else if (ph == 2'd0) begin
        blue_green_d[7:0] = byte_in.data_byte;
        byte_phase_d      = 2'd1;
      end else if (ph == 2'd1) begin
        blue_green_d[15:8] = byte_in.data_byte;
        byte_phase_d       = 2'd2;
      end else begin
        byte_phase_d = 2'd0;
        if (row >= h_eff) begin
          done_d = 1'b1;
        end else begin
          if (SCOL_W'(col) + SCOL_W'(1) >= SCOL_W'(w_eff)) begin
            column_d = '0;
            if (SROW_W'(row) + SROW_W'(1) >= SROW_W'(h_eff)) begin
              done_d     = 1'b1;
              cmd_o.last = 1'b1;
            end else begin
              row_d      = row + HGT_W'(1);
              pad_left_d = w_eff[1:0];
            end
          end else begin
            column_d = col + WID_W'(1);
          end
          push_o = (32'(scr_col) < SCREEN_WIDTH) && (32'(scr_row) < SCREEN_HEIGHT);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_left_q <= HDR_W'(HEADER_BYTES);
      byte_phase_q  <= '0;
      blue_green_q  <= '0;
      column_q      <= '0;
      row_q         <= '0;
      pad_left_q    <= '0;
      done_q        <= 1'b0;
    end else begin
      header_left_q <= header_left_d;
      byte_phase_q  <= byte_phase_d;
      blue_green_q  <= blue_green_d;
      column_q      <= column_d;
      row_q         <= row_d;
      pad_left_q    <= pad_left_d;
      done_q        <= done_d;
    end
  end

endmodule

### hw/rtl/bmp_fb_queue.sv
`timescale 1ns / 1ps

module bmp_fb_queue import bmp_fb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_cmd_t cmd_i,
  input  logic     pop_i,
  output pix_cmd_t head_o,
  output q_stat_t  stat_o
);

  pix_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.level = count_q;
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hw/rtl/bmp_fb_back.sv
`timescale 1ns / 1ps

module bmp_fb_back import bmp_fb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pix_cmd_t    head_i,
  input  q_stat_t     q_stat_i,
  output logic        pop_o,
  bmp_fb_pix_if.source pix_out
);

  logic               valid_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [PIXEL_W-1:0] pixel_q;
  logic               last_q;

  // output register is free when empty or being taken this cycle
  assign pop_o  = !q_stat_i.empty && (!valid_q || pix_out.ready);
  assign addr_d = ADDR_W'(32'(head_i.row) * SCREEN_WIDTH + 32'(head_i.col));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (pix_out.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q  <= addr_d;
      pixel_q <= head_i.pixel;
      last_q  <= head_i.last;
    end
  end

  assign pix_out.valid       = valid_q;
  assign pix_out.fb_address  = addr_q;
  assign pix_out.pixel_value = pixel_q;
  assign pix_out.last_pixel  = last_q;

endmodule

### hw/rtl/bmp_stream_to_framebuffer_writer.sv
// 24-bit BMP byte stream to framebuffer pixel writes.
// byte_in takes one file byte per item (valid/ready), start_of_file marks
// the first byte of a file and restarts header, pad, column and row counting.
// pix_out gives one item per on-screen pixel: word address, 24-bit 0xRRGGBB value
// and last_pixel on the image's final pixel. Off-screen pixels are dropped.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 dest_x, 1 dest_y, 2 image_width, 3 image_height); write only when idle.
// Throughput: one byte per cycle while the queue is not full, so one pixel per three bytes at most.
// Path: the accepting edge writes a pixel into the 4-entry command queue;
// from the queue head it is loaded into the output register, where the
// address multiply-add is done, as soon as that register is free.
// Stall: when pix_out.ready is low the output holds; the queue absorbs up to
// four pixels, then byte_in.ready drops until the receiver takes one.
// Reset: counters restart, registers return to 0, 0, 800, 480, queue and
// output empty.
`timescale 1ns / 1ps
`include "bmp_stream_to_framebuffer_writer_defines.svh"

module bmp_stream_to_framebuffer_writer import bmp_fb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bmp_fb_byte_if.sink           byte_in,
  bmp_fb_pix_if.source          pix_out
);

  cfg_t     cfg_q;
  logic     push, pop;
  pix_cmd_t cmd, head;
  q_stat_t  q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x       <= '0;
      cfg_q.dest_y       <= '0;
      cfg_q.image_width  <= WID_W'(800);
      cfg_q.image_height <= HGT_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEST_X:       cfg_q.dest_x       <= cfg_data_i[DX_W-1:0];
        CFG_DEST_Y:       cfg_q.dest_y       <= cfg_data_i[DY_W-1:0];
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[WID_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[HGT_W-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  bmp_fb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .byte_in  (byte_in),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  bmp_fb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  bmp_fb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .pix_out  (pix_out)
  );

  `BMP_ASSERT_IMPL(a_addr_on_screen, clk_i, rst_ni, pix_out.valid, 32'(pix_out.fb_address) < FB_WORDS)
  `BMP_ASSERT_IMPL(a_level_bounded, clk_i, rst_ni, 1'b1, 32'(q_stat.level) <= QUEUE_DEPTH)
  `BMP_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push && !pop, !q_stat.empty)

endmodule
